FILE: design/odo_pkg.sv
package odo_pkg;

  // field and datapath widths
  localparam int RawW    = 16;               // encoder counter
  localparam int CountW  = 32;               // wheel count and distance
  localparam int CoefW   = 24;               // Q8.16 scale registers
  localparam int FracW   = 16;               // fraction bits of the scale registers
  localparam int MulAW   = CountW + 1;       // magnitude operand, holds |right - left|
  localparam int ProdW   = MulAW + CoefW;    // full product
  localparam int ScaledW = ProdW - FracW;    // product after dropping the fraction
  localparam int HeadW   = 9;                // heading field
  localparam int RemW    = 9;                // remainder by a full turn
  localparam int RemSteps = 4;               // pipeline depth of the remainder unit
  localparam int StepW   = $clog2(RemSteps + 1);

  localparam int Modulus  = 360;
  localparam int HalfTurn = 180;

  localparam logic [CoefW-1:0] MmPerCountReset = CoefW'(18300);
  localparam logic [CoefW-1:0] DegPerMmReset   = CoefW'(46935);

  typedef enum logic [0:0] {
    REG_MM_PER_COUNT = 1'b0,
    REG_DEG_PER_MM   = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic               start;
    logic [ScaledW-1:0] dividend;
  } rem_ctrl_t;

  typedef struct packed {
    logic            busy;
    logic [RemW-1:0] remainder;
  } rem_stat_t;

endpackage

FILE: design/odo_capture_if.sv
interface odo_capture_if import odo_pkg::*;;
  logic            valid;
  logic            ready;
  logic            wheel_side;
  logic [RawW-1:0] raw_counter;

  modport source(output valid, wheel_side, raw_counter, input ready);
  modport sink(input valid, wheel_side, raw_counter, output ready);
endinterface

FILE: design/odo_result_if.sv
interface odo_result_if import odo_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [CountW-1:0] left_distance;
  logic signed [CountW-1:0] right_distance;
  logic signed [CountW-1:0] center_distance;
  logic signed [HeadW-1:0]  heading_degrees;

  modport source(output valid, left_distance, right_distance, center_distance,
                 heading_degrees, input ready);
  modport sink(input valid, left_distance, right_distance, center_distance,
               heading_degrees, output ready);
endinterface

FILE: design/odo_mul.sv
// Shared magnitude multiplier: operands registered on load, product registered.
module odo_mul import odo_pkg::*; (
  input  logic             clk,
  input  logic             load,
  input  logic [MulAW-1:0] a,
  input  logic [CoefW-1:0] b,
  output logic [ProdW-1:0] prod
);

  logic [MulAW-1:0] opnd_a;
  logic [CoefW-1:0] opnd_b;

  always_ff @(posedge clk) begin
    if (load) begin
      opnd_a <= a;
      opnd_b <= b;
    end
    prod <= ProdW'(opnd_a) * ProdW'(opnd_b);
  end

endmodule

FILE: design/odo_rem360.sv
// Remainder by a full turn in a four-stage pipeline.
// 360 = 8 * 45: the low three bits pass through, the upper part is reduced
// mod 45. Since 2^12 = 1 (mod 45), its 12-bit chunks sum to the same residue;
// the small sum is finished with a reciprocal multiply and one subtract.
module odo_rem360 import odo_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  rem_ctrl_t ctrl,
  output rem_stat_t stat
);

  localparam int LowW       = 3;
  localparam int OddMod     = Modulus >> LowW;   // 45
  localparam int ChunkW     = 12;
  localparam int RecipMul   = 11651;             // ceil(2^19 / 45)
  localparam int RecipShift = 19;
  localparam int Sum1W      = ChunkW + 2;
  localparam int Sum2W      = ChunkW + 1;
  localparam int QuotW      = 7;
  localparam int ResW       = RemW - LowW;
  localparam int RecipW     = Sum2W + 14;

  logic [ScaledW-1:0] dividend;
  logic [StepW-1:0]   steps;
  logic [Sum1W-1:0]   sum1;
  logic [LowW-1:0]    low1;
  logic [Sum2W-1:0]   sum2;
  logic [LowW-1:0]    low2;
  logic [QuotW-1:0]   quot;
  logic [Sum2W-1:0]   sum3;
  logic [LowW-1:0]    low3;
  logic [RecipW-1:0]  recip_prod;
  logic [Sum2W-1:0]   odd_rem;
  logic [RemW-1:0]    remainder;

  // exact quotient by 45 for any sum below 5760
  assign recip_prod = RecipW'(sum2) * RecipW'(RecipMul);
  assign odd_rem    = sum3 - Sum2W'(quot) * Sum2W'(OddMod);

  always_ff @(posedge clk) begin
    if (rst) begin
      steps     <= '0;
      dividend  <= '0;
      sum1      <= '0;
      low1      <= '0;
      sum2      <= '0;
      low2      <= '0;
      quot      <= '0;
      sum3      <= '0;
      low3      <= '0;
      remainder <= '0;
    end else begin
      if (ctrl.start) begin
        steps    <= StepW'(RemSteps);
        dividend <= ctrl.dividend;
      end else if (steps != '0) begin
        steps <= steps - StepW'(1);
      end
      sum1 <= Sum1W'(dividend[LowW +: ChunkW]) + Sum1W'(dividend[LowW + ChunkW +: ChunkW])
            + Sum1W'(dividend[LowW + 2*ChunkW +: ChunkW])
            + Sum1W'(dividend[ScaledW-1:LowW + 3*ChunkW]);
      low1 <= dividend[LowW-1:0];
      sum2 <= Sum2W'(sum1[ChunkW-1:0]) + Sum2W'(sum1[Sum1W-1:ChunkW]);
      low2 <= low1;
      quot <= recip_prod[RecipShift +: QuotW];
      sum3 <= sum2;
      low3 <= low2;
      remainder <= {odd_rem[ResW-1:0], low3};
    end
  end

  assign stat.busy      = (steps != '0);
  assign stat.remainder = remainder;

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    ctrl.start |=> stat.busy)
    else $error("remainder unit not busy after start");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    stat.busy |-> (remainder < RemW'(Modulus)))
    else $error("partial remainder reached a full turn");

  a_steps_bound: assert property (@(posedge clk) disable iff (rst)
    steps <= StepW'(RemSteps))
    else $error("remainder step count out of range");

endmodule

FILE: design/two_wheel_encoder_odometry_unit.sv
// Differential-drive wheel odometry. Each transfer on capture carries one
// 16-bit counter capture from the left (wheel_side 0) or right (1) encoder.
// The wrapped signed difference from that wheel's previous capture is
// subtracted from its 32-bit count (direction inverted), and the wheel
// distance is count * mm_per_count_q16 >> 16, truncated toward zero and
// wrapped to 32 bits. Each capture produces one transfer on result with both
// wheel distances, their mean truncated toward zero, and the heading:
// (right - left) * deg_per_mm_q16 >> 16 truncated, remainder by 360 with the
// sign of the dividend, folded into -180..180. The uncaptured wheel keeps its
// stored distance. The idle state takes the transfer; the wheel product and
// then the heading product are each loaded, multiplied and written back
// through the single 33x24 multiplier; the 41-bit scaled heading goes to the
// pipelined remainder by 360; a last state folds it and loads the output
// register. The output register lets the next capture start while a result
// waits; capture.ready is high only between items. Configuration writes
// (cfg_index 0: mm_per_count_q16, 1: deg_per_mm_q16) go on cfg_write and must
// be made only while the block is idle.
module two_wheel_encoder_odometry_unit import odo_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [0:0]          cfg_index,
  input  logic [CoefW-1:0]    cfg_data,
  odo_capture_if.sink         capture,
  odo_result_if.source        result
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_LOAD_W = 9'b000000010,
    S_MUL_W  = 9'b000000100,
    S_WB_W   = 9'b000001000,
    S_LOAD_H = 9'b000010000,
    S_MUL_H  = 9'b000100000,
    S_WB_H   = 9'b001000000,
    S_MOD    = 9'b010000000,
    S_FINISH = 9'b100000000
  } state_t;

  state_t state, state_next;

  // configuration
  logic [CoefW-1:0] mm_per_count;
  logic [CoefW-1:0] deg_per_mm;

  // per-wheel state
  logic [RawW-1:0]   last_left, last_right;
  logic [CountW-1:0] count_left, count_right;
  logic [CountW-1:0] dist_left, dist_right;

  logic side;   // wheel of the item in flight
  logic neg;    // sign of the value now in the multiplier

  // output register
  logic              out_valid;
  logic [CountW-1:0] out_left, out_right, out_center;
  logic [HeadW-1:0]  out_heading;

  logic accept, out_take, out_load;

  // count update
  logic [RawW-1:0]   sel_last;
  logic [CountW-1:0] sel_count;
  logic [RawW-1:0]   raw_diff;
  logic [CountW-1:0] new_count;
  logic [CountW-1:0] count_cur;
  logic [CountW-1:0] count_mag;

  // heading operand
  logic [MulAW-1:0] wheel_diff;
  logic [MulAW-1:0] diff_mag;

  // shared multiplier
  logic             mul_load;
  logic [MulAW-1:0] mul_a;
  logic [CoefW-1:0] mul_b;
  logic [ProdW-1:0] prod;
  logic [CountW-1:0] prod_dist;
  logic [CountW-1:0] dist_new;

  rem_ctrl_t rem_ctrl;
  rem_stat_t rem_stat;

  // result assembly
  logic [MulAW-1:0] dist_sum;
  logic [MulAW-1:0] dist_sum_adj;
  logic [RemW:0]    rem_ext;
  logic [RemW:0]    head_fold;

  assign accept   = capture.valid && capture.ready;
  assign out_take = out_valid && result.ready;
  assign out_load = (state == S_FINISH) && (!out_valid || result.ready);

  assign capture.ready = (state == S_IDLE);

  // wrapped signed delta, subtracted so the counter direction is inverted
  assign sel_last  = capture.wheel_side ? last_right : last_left;
  assign sel_count = capture.wheel_side ? count_right : count_left;
  assign raw_diff  = capture.raw_counter - sel_last;
  assign new_count = sel_count - {{(CountW - RawW){raw_diff[RawW-1]}}, raw_diff};

  assign count_cur = side ? count_right : count_left;
  assign count_mag = count_cur[CountW-1] ? (CountW'(0) - count_cur) : count_cur;

  assign wheel_diff = {dist_right[CountW-1], dist_right} - {dist_left[CountW-1], dist_left};
  assign diff_mag   = wheel_diff[MulAW-1] ? (MulAW'(0) - wheel_diff) : wheel_diff;

  always_comb begin
    mul_load = 1'b0;
    mul_a    = {1'b0, count_mag};
    mul_b    = mm_per_count;
    case (state)
      S_LOAD_W: begin
        mul_load = 1'b1;
      end
      S_LOAD_H: begin
        mul_load = 1'b1;
        mul_a    = diff_mag;
        mul_b    = deg_per_mm;
      end
      default: begin
        mul_load = 1'b0;
      end
    endcase
  end

  odo_mul u_mul (
    .clk  (clk),
    .load (mul_load),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // drop the fraction, restore the sign, keep the low 32 bits
  assign prod_dist = prod[FracW +: CountW];
  assign dist_new  = neg ? (CountW'(0) - prod_dist) : prod_dist;

  assign rem_ctrl.start    = (state == S_WB_H);
  assign rem_ctrl.dividend = prod[ProdW-1:FracW];

  odo_rem360 u_rem (
    .clk  (clk),
    .rst  (rst),
    .ctrl (rem_ctrl),
    .stat (rem_stat)
  );

  // truncating mean: bias negative sums by one before the halving shift
  assign dist_sum     = {dist_left[CountW-1], dist_left} + {dist_right[CountW-1], dist_right};
  assign dist_sum_adj = dist_sum + MulAW'(dist_sum[MulAW-1]);

  // remainder keeps the dividend's sign, then fold past half a turn
  assign rem_ext = {1'b0, rem_stat.remainder};
  always_comb begin
    if (neg) begin
      head_fold = (rem_ext > (RemW + 1)'(HalfTurn)) ? ((RemW + 1)'(Modulus) - rem_ext)
                                                    : ((RemW + 1)'(0) - rem_ext);
    end else begin
      head_fold = (rem_ext > (RemW + 1)'(HalfTurn)) ? (rem_ext - (RemW + 1)'(Modulus))
                                                    : rem_ext;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept) state_next = S_LOAD_W;
      S_LOAD_W: state_next = S_MUL_W;
      S_MUL_W:  state_next = S_WB_W;
      S_WB_W:   state_next = S_LOAD_H;
      S_LOAD_H: state_next = S_MUL_H;
      S_MUL_H:  state_next = S_WB_H;
      S_WB_H:   state_next = S_MOD;
      S_MOD:    if (!rem_stat.busy) state_next = S_FINISH;
      S_FINISH: if (out_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      mm_per_count <= MmPerCountReset;
      deg_per_mm   <= DegPerMmReset;
      last_left    <= '0;
      last_right   <= '0;
      count_left   <= '0;
      count_right  <= '0;
      dist_left    <= '0;
      dist_right   <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        case (cfg_index)
          REG_MM_PER_COUNT: mm_per_count <= cfg_data;
          REG_DEG_PER_MM:   deg_per_mm   <= cfg_data;
          default:          mm_per_count <= mm_per_count;
        endcase
      end

      if (accept) begin
        if (capture.wheel_side) begin
          last_right  <= capture.raw_counter;
          count_right <= new_count;
        end else begin
          last_left  <= capture.raw_counter;
          count_left <= new_count;
        end
      end

      if (state == S_WB_W) begin
        if (side) dist_right <= dist_new;
        else      dist_left  <= dist_new;
      end

      if (out_load)      out_valid <= 1'b1;
      else if (out_take) out_valid <= 1'b0;
    end
  end

  // datapath holding registers
  always_ff @(posedge clk) begin
    if (accept) side <= capture.wheel_side;
    if (state == S_LOAD_W) neg <= count_cur[CountW-1];
    if (state == S_LOAD_H) neg <= wheel_diff[MulAW-1];
    if (out_load) begin
      out_left    <= dist_left;
      out_right   <= dist_right;
      out_center  <= dist_sum_adj[MulAW-1:1];
      out_heading <= head_fold[HeadW-1:0];
    end
  end

  assign result.valid           = out_valid;
  assign result.left_distance   = out_left;
  assign result.right_distance  = out_right;
  assign result.center_distance = out_center;
  assign result.heading_degrees = out_heading;

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_LOAD_W))
    else $error("capture transfer did not start the sequence");

  a_idle_rem_quiet: assert property (@(posedge clk) disable iff (rst)
    capture.ready |-> !rem_stat.busy)
    else $error("remainder unit busy while taking a capture");

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> ((result.heading_degrees >= -180) && (result.heading_degrees <= 180)))
    else $error("heading outside half a turn");

endmodule

FILE: tb/sv/odo_tb_pkg.sv
`timescale 1ns / 1ps

package odo_tb_pkg;
  import odo_pkg::*;

  typedef struct {
    logic signed [CountW-1:0] left_mm;
    logic signed [CountW-1:0] right_mm;
    logic signed [CountW-1:0] center_mm;
    logic signed [HeadW-1:0]  heading_deg;
  } odometry_t;

  class odometry_scoreboard;
    logic [RawW-1:0]   last_raw [2];
    logic [CountW-1:0] wheel_count [2];
    logic [CountW-1:0] wheel_dist [2];
    logic [CoefW-1:0]  mm_scale;
    logic [CoefW-1:0]  deg_scale;
    odometry_t         pending_odometry [$];
    int                errors;
    int                results_seen;

    function new();
      foreach (last_raw[i]) begin
        last_raw[i]    = '0;
        wheel_count[i] = '0;
        wheel_dist[i]  = '0;
      end
      mm_scale     = MmPerCountReset;
      deg_scale    = DegPerMmReset;
      errors       = 0;
      results_seen = 0;
    endfunction

    // signed value times Q8.16 factor, truncated toward zero
    static function longint apply_q16_scale(longint v, logic [CoefW-1:0] factor);
      longint unsigned mag;
      longint unsigned prod;
      mag  = (v < 0) ? longint'(-v) : v;
      prod = (mag * factor) >> FracW;
      return (v < 0) ? -longint'(prod) : longint'(prod);
    endfunction

    function int pending();
      return pending_odometry.size();
    endfunction

    // accepted capture: advance the wheel and queue the odometry it yields
    function void note_capture(logic side, logic [RawW-1:0] raw);
      logic [RawW-1:0] diff;
      longint          l;
      longint          r;
      longint          turn;
      odometry_t       exp_odo;
      diff = raw - last_raw[side];
      // counter direction is inverted
      wheel_count[side] = wheel_count[side] - {{(CountW-RawW){diff[RawW-1]}}, diff};
      last_raw[side]    = raw;
      wheel_dist[side]  = CountW'(apply_q16_scale(longint'($signed(wheel_count[side])),
                                                  mm_scale));
      l = longint'($signed(wheel_dist[0]));
      r = longint'($signed(wheel_dist[1]));
      turn = apply_q16_scale(r - l, deg_scale) % Modulus;
      if (turn > HalfTurn) begin
        turn -= Modulus;
      end else if (turn < -HalfTurn) begin
        turn += Modulus;
      end
      exp_odo.left_mm     = wheel_dist[0];
      exp_odo.right_mm    = wheel_dist[1];
      exp_odo.center_mm   = CountW'((l + r) / 2);
      exp_odo.heading_deg = HeadW'(turn);
      pending_odometry.push_back(exp_odo);
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("MISMATCH %0d: %s", errors, what);
    endtask

    task compare_field(string name, longint got, longint want);
      if (got != want) report($sformatf("result %0d %s got %0d expected %0d",
                                        results_seen, name, got, want));
    endtask

    task check_result(logic signed [CountW-1:0] left_mm, logic signed [CountW-1:0] right_mm,
                      logic signed [CountW-1:0] center_mm,
                      logic signed [HeadW-1:0] heading_deg);
      odometry_t exp_odo;
      if (pending_odometry.size() == 0) begin
        report($sformatf("result with no capture behind it: %0d %0d %0d %0d",
                         left_mm, right_mm, center_mm, heading_deg));
        return;
      end
      exp_odo = pending_odometry.pop_front();
      compare_field("left_distance", left_mm, exp_odo.left_mm);
      compare_field("right_distance", right_mm, exp_odo.right_mm);
      compare_field("center_distance", center_mm, exp_odo.center_mm);
      compare_field("heading_degrees", heading_deg, exp_odo.heading_deg);
      results_seen++;
    endtask
  endclass

endpackage

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import odo_pkg::*;
  import odo_tb_pkg::*;

  localparam int QuietLimit = 5000;   // cycles with no transfer on either side
  localparam int HoldCycles = 400;    // long receiver hold-off
  localparam int DrainWait  = 100;    // final wait before the verdict

  logic             clk;
  logic             rst;
  logic             cfg_write;
  reg_index_t       cfg_index;
  logic [CoefW-1:0] cfg_data;

  odo_capture_if cap();
  odo_result_if  res();

  two_wheel_encoder_odometry_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .capture   (cap),
    .result    (res)
  );

  odometry_scoreboard sb = new();

  int items_sent   = 0;
  int quiet_cycles = 0;
  bit held_off     = 1'b0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------------------
  // Capture side. Inputs move at the falling edge; a transfer is seen at the
  // rising edge. Valid stays up from one item to the next unless a random gap
  // is drawn, so back-to-back transfers happen too.
  // ---------------------------------------------------------------------------
  task automatic send_capture(input logic side, input logic [RawW-1:0] raw);
    @(negedge clk);
    // no gaps while a middle stretch of items goes out
    while (!(items_sent >= 760 && items_sent < 960) && $urandom_range(99) < 11) begin
      cap.valid = 1'b0;
      @(negedge clk);
    end
    cap.valid       = 1'b1;
    cap.wheel_side  = side;
    cap.raw_counter = raw;
    do @(posedge clk); while (!cap.ready);
    sb.note_capture(side, raw);
    items_sent++;
  endtask

  // drop valid and wait until every queued result has come back
  task automatic settle();
    @(negedge clk);
    cap.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // only called with the block idle
  task automatic write_scales(input logic [CoefW-1:0] mm, input logic [CoefW-1:0] deg);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = REG_MM_PER_COUNT;
    cfg_data  = mm;
    @(posedge clk);
    sb.mm_scale = mm;
    @(negedge clk);
    cfg_index = REG_DEG_PER_MM;
    cfg_data  = deg;
    @(posedge clk);
    sb.deg_scale = deg;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // same wheel, same counter step, over and over: drives the count far out
  task automatic run_streak(input logic side, input logic [RawW-1:0] step, input int len);
    for (int i = 0; i < len; i++) send_capture(side, sb.last_raw[side] + step);
  endtask

  // Random encoder motion: small steps, big jumps, runs of one repeated step
  // and unrelated counter values.
  task automatic run_random(input int count);
    int              done;
    int              pick;
    int              len;
    logic            side;
    logic [RawW-1:0] step;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(99);
      side = 1'($urandom_range(1));
      len  = 1;
      if (pick < 60) begin
        send_capture(side, sb.last_raw[side] + RawW'($urandom_range(80)) - RawW'(40));
      end else if (pick < 75) begin
        send_capture(side, sb.last_raw[side] + RawW'($urandom));
      end else if (pick < 88) begin
        len  = $urandom_range(4, 24);
        step = $urandom_range(1) ? 16'h8000 : RawW'($urandom);
        if (len > count - done) len = count - done;
        run_streak(side, step, len);
      end else begin
        send_capture(side, RawW'($urandom));
      end
      done += len;
    end
  endtask

  // At unity scales the heading is (count_r - count_l) mod 360; step the left
  // counter so the difference lands on the wanted residue.
  task automatic aim_heading(input int residue);
    longint m;
    m = (longint'($signed(sb.wheel_count[0])) - longint'($signed(sb.wheel_count[1]))
         + residue) % Modulus;
    if (m < 0) m += Modulus;
    send_capture(1'b0, sb.last_raw[0] + RawW'(m));
  endtask

  // ---------------------------------------------------------------------------
  // Result side. Ready is redrawn every falling edge, with one long hold-off
  // so the output register fills and capture.ready drops.
  // ---------------------------------------------------------------------------
  initial begin
    res.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && sb.results_seen >= 730) begin
        held_off  = 1'b1;
        res.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end
      res.ready = (sb.results_seen >= 760 && sb.results_seen < 960) ||
                  $urandom_range(99) >= 11;
    end
  end

  always @(posedge clk) begin
    if (!rst && res.valid && res.ready)
      sb.check_result(res.left_distance, res.right_distance, res.center_distance,
                      res.heading_degrees);
  end

  // watchdog: any transfer restarts the count
  always @(posedge clk) begin
    if (rst || (cap.valid && cap.ready) || (res.valid && res.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst             = 1'b1;
    cfg_write       = 1'b0;
    cfg_index       = REG_MM_PER_COUNT;
    cfg_data        = '0;
    cap.valid       = 1'b0;
    cap.wheel_side  = 1'b0;
    cap.raw_counter = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset scales; zero step, unit steps, counter wrap both ways, half-range
    // jumps (read as -32768), largest positive step
    send_capture(1'b0, 16'h0000);
    send_capture(1'b1, 16'h0000);
    send_capture(1'b0, 16'h0001);
    send_capture(1'b0, 16'h0000);
    send_capture(1'b0, 16'hFFFF);
    send_capture(1'b0, 16'h7FFF);
    send_capture(1'b0, 16'hFFFF);
    send_capture(1'b0, 16'h7FFE);
    send_capture(1'b1, 16'h8000);
    send_capture(1'b1, 16'h0000);
    send_capture(1'b1, 16'hFFFF);
    send_capture(1'b1, 16'h0001);
    send_capture(1'b1, 16'hAAAA);
    send_capture(1'b1, 16'h5555);
    settle();

    // zero scales: everything collapses to zero
    write_scales('0, '0);
    run_random(100);
    settle();

    // full-scale factors; a long one-direction run on the left pushes the
    // exact distance past 32 bits so it wraps
    write_scales('1, '1);
    run_streak(1'b0, 16'h8000, 300);
    run_random(150);
    settle();

    // unity scales: hit the heading fold edges directly
    write_scales(CoefW'(1 << FracW), CoefW'(1 << FracW));
    send_capture(1'b1, sb.last_raw[1]);
    aim_heading(HalfTurn);
    aim_heading(HalfTurn + 1);
    aim_heading(Modulus - 1);
    aim_heading(0);
    aim_heading(1);
    aim_heading(HalfTurn - 1);
    aim_heading(Modulus - HalfTurn - 1);
    run_random(150);
    settle();

    // back to the reset values; the receiver hold-off and the no-gap
    // stretch fall in this phase
    write_scales(MmPerCountReset, DegPerMmReset);
    run_random(350);
    settle();

    write_scales(CoefW'($urandom_range(0, 24'hFFFFFF)), CoefW'($urandom_range(0, 24'hFFFFFF)));
    run_random(100);
    settle();

    repeat (DrainWait) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
